// ===== rtl/tcpop_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcpop_pkg
// Shared types and constants for the tcp option area parser.
// ----------------------------------------------------------------------------
package tcpop_pkg;

  localparam logic [7:0]  KIND_END       = 8'd0;
  localparam logic [7:0]  KIND_NOP       = 8'd1;
  localparam logic [7:0]  KIND_MSS       = 8'd2;
  localparam logic [7:0]  KIND_WSCALE    = 8'd3;
  localparam logic [7:0]  KIND_SACK_OK   = 8'd4;

  localparam logic [7:0]  LEN_MSS        = 8'd4;
  localparam logic [7:0]  LEN_WSCALE     = 8'd3;
  localparam logic [7:0]  LEN_SACK       = 8'd2;
  localparam logic [7:0]  LEN_MIN        = 8'd2;

  localparam logic [15:0] MSS_RESET      = 16'd1452;

  typedef struct packed {
    logic [7:0] option_byte;
    logic       has_byte;
    logic       last_byte;
  } opt_item_t;

  typedef struct packed {
    logic        parse_ok;
    logic [15:0] max_segment_size;
    logic [7:0]  window_scale;
    logic        sack_permitted;
  } opt_result_t;

endpackage
`default_nettype wire

// ===== rtl/tcpop_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcpop_core
// Per-byte option parser: kind/length/data tracking and result build.
// ----------------------------------------------------------------------------
module tcpop_core import tcpop_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        stage_valid,
  input  wire opt_item_t   stage_item,
  input  wire logic        out_free,
  input  wire logic [15:0] default_mss,
  output logic             advance,
  output logic             emit,
  output opt_result_t      result
);

  typedef enum logic [1:0] {PH_KIND, PH_LEN, PH_DATA, PH_SKIP} phase_t;

  phase_t      phase;
  logic [7:0]  kind;
  logic [7:0]  left;
  logic [7:0]  len;
  logic [15:0] acc;
  logic [15:0] mss_value;
  logic        mss_found;
  logic [7:0]  scale;
  logic        sack;
  logic        err;

  phase_t      phase_next;
  logic [7:0]  kind_next;
  logic [7:0]  left_next;
  logic [7:0]  len_next;
  logic [15:0] acc_next;
  logic [15:0] mss_value_next;
  logic        mss_found_next;
  logic [7:0]  scale_next;
  logic        sack_next;
  logic        err_next;

  logic        fin;
  logic [7:0]  fin_len;
  logic [15:0] fin_acc;
  logic [7:0]  b;
  logic        err_res;

  assign b = stage_item.option_byte;

  always_comb begin
    phase_next     = phase;
    kind_next      = kind;
    left_next      = left;
    len_next       = len;
    acc_next       = acc;
    mss_value_next = mss_value;
    mss_found_next = mss_found;
    scale_next     = scale;
    sack_next      = sack;
    err_next       = err;
    fin            = 1'b0;
    fin_len        = len;
    fin_acc        = acc;
    if (stage_item.has_byte) begin
      unique case (phase)
        PH_KIND: begin
          if (b == KIND_END) begin
            phase_next = PH_SKIP;
          end else if (b != KIND_NOP) begin
            kind_next  = b;
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b < LEN_MIN) begin
            err_next   = 1'b1;
            phase_next = PH_SKIP;
          end else begin
            len_next  = b;
            left_next = b - LEN_MIN;
            acc_next  = '0;
            fin_len   = b;
            fin_acc   = '0;
            if (b == LEN_MIN) begin
              fin = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          acc_next  = {acc[7:0], b};
          left_next = left - 8'd1;
          fin_acc   = {acc[7:0], b};
          fin       = (left == 8'd1);
        end
        PH_SKIP: begin
        end
      endcase
    end
    // known kinds count only at their exact length
    if (fin) begin
      if (kind == KIND_MSS && fin_len == LEN_MSS) begin
        mss_value_next = fin_acc;
        mss_found_next = 1'b1;
      end else if (kind == KIND_WSCALE && fin_len == LEN_WSCALE) begin
        scale_next = fin_acc[7:0];
      end else if (kind == KIND_SACK_OK && fin_len == LEN_SACK) begin
        sack_next = 1'b1;
      end
      phase_next = PH_KIND;
    end
  end

  // area ending mid-option is an overrun
  assign err_res = err_next || phase_next == PH_LEN || phase_next == PH_DATA;
  assign emit    = !stage_item.has_byte || stage_item.last_byte;
  assign advance = stage_valid && (!emit || out_free);

  always_comb begin
    result.parse_ok = !err_res;
    if (err_res) begin
      result.max_segment_size = default_mss;
      result.window_scale     = '0;
      result.sack_permitted   = 1'b0;
    end else begin
      result.max_segment_size = mss_found_next ? mss_value_next : default_mss;
      result.window_scale     = scale_next;
      result.sack_permitted   = sack_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && emit)) begin
      phase     <= PH_KIND;
      kind      <= '0;
      left      <= '0;
      len       <= '0;
      acc       <= '0;
      mss_value <= MSS_RESET;
      mss_found <= 1'b0;
      scale     <= '0;
      sack      <= 1'b0;
      err       <= 1'b0;
    end else if (advance) begin
      phase     <= phase_next;
      kind      <= kind_next;
      left      <= left_next;
      len       <= len_next;
      acc       <= acc_next;
      mss_value <= mss_value_next;
      mss_found <= mss_found_next;
      scale     <= scale_next;
      sack      <= sack_next;
      err       <= err_next;
    end
  end

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    advance && emit |=> phase == PH_KIND && !err && !mss_found && !sack)
    else $error("parser state not cleared after result");

  a_result_has_room: assert property (@(posedge clk) disable iff (rst)
    advance && emit |-> out_free)
    else $error("result produced with no room in result register");

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    emit && !result.parse_ok |->
      result.max_segment_size == default_mss && result.window_scale == 8'd0 &&
      !result.sack_permitted)
    else $error("error result carries parsed values");

endmodule
`default_nettype wire

// ===== rtl/tcpop_out_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcpop_out_reg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module tcpop_out_reg import tcpop_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire opt_result_t load_data,
  output logic             free,
  output logic             result_valid,
  input  wire logic        result_stall,
  output opt_result_t      result
);

  assign free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (load) begin
      result <= load_data;
    end
  end

  a_drain: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !load |=> !result_valid)
    else $error("result repeated after transfer");

endmodule
`default_nettype wire

// ===== rtl/tcp_option_parser_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_option_parser_top
// TCP header option parser: MSS, window scale and SACK-permitted extraction.
// ----------------------------------------------------------------------------
// Takes one option byte per clock while item_stall is low. A byte transfer
// lands in an input stage register and is parsed from there; a result (on a
// last byte or an empty item) is then loaded into the result register, which
// raises result_valid, and the result transfers while result_stall is low.
// Sustained rate is one item per cycle, set by the combinational parse step
// between the input stage and the result register; only a stalled, full
// result register holds the input back. cfg_ready is always high; default_mss
// resets to 1452 and should be written only while the parser is idle.
module tcp_option_parser_top import tcpop_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire opt_item_t   item,
  output logic             result_valid,
  input  wire logic        result_stall,
  output opt_result_t      result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic        stage_valid;
  opt_item_t   stage_item;
  logic        advance;
  logic        emit;
  logic        out_free;
  opt_result_t core_result;
  logic [15:0] default_mss;

  assign cfg_ready  = 1'b1;
  assign item_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_mss <= MSS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      default_mss <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
    if (item_valid && !item_stall) begin
      stage_item <= item;
    end
  end

  tcpop_core u_core (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .out_free    (out_free),
    .default_mss (default_mss),
    .advance     (advance),
    .emit        (emit),
    .result      (core_result)
  );

  tcpop_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && emit),
    .load_data    (core_result),
    .free         (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire

// ===== test/tcp_option_parser_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcp_option_parser_top_tb
// Self-checking bench for the tcp option area parser. A table of directed
// option areas is followed by random areas, mostly well formed, across several
// default mss settings. Every closing transfer is predicted by a local parser
// model or a typed table row, and matched in order against the result channel, under random idling.
// ----------------------------------------------------------------------------
module tcp_option_parser_top_tb;
  import tcpop_pkg::*;

  typedef enum logic [2:0] {PH_KIND, PH_LEN, PH_DATA, PH_SKIP} parse_phase_e;

  typedef struct packed {
    opt_item_t   it;
    logic        typed;
    opt_result_t res;
  } stim_row_t;

  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 150;
  localparam int DRAIN_WAIT  = 8;

  localparam opt_result_t NO_RESULT     = '0;
  localparam opt_result_t AREA_DEFAULTS = '{1'b1, MSS_RESET, 8'd0, 1'b0};
  localparam opt_result_t AREA_REJECTED = '{1'b0, MSS_RESET, 8'd0, 1'b0};

  localparam int DIRECTED_ROWS = 25;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // empty area right after reset, then an empty item with last set and has_byte clear
    '{'{8'h00, 1'b0, 1'b0}, 1'b1, AREA_DEFAULTS},
    '{'{8'hFF, 1'b0, 1'b1}, 1'b1, AREA_DEFAULTS},
    // largest mss
    '{'{KIND_MSS, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{LEN_MSS, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b1, 1'b1}, 1'b1, '{1'b1, 16'hFFFF, 8'd0, 1'b0}},
    // nop, largest window scale, sack permitted
    '{'{KIND_NOP, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{KIND_WSCALE, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{LEN_WSCALE, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{KIND_SACK_OK, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{LEN_SACK, 1'b1, 1'b1}, 1'b1, '{1'b1, MSS_RESET, 8'hFF, 1'b1}},
    // length below minimum
    '{'{8'h05, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h01, 1'b1, 1'b1}, 1'b1, AREA_REJECTED},
    // area ends inside option data
    '{'{KIND_MSS, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{LEN_MSS, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b1, 1'b1}, 1'b1, AREA_REJECTED},
    // unknown kind, mss with wrong length, end with a trailing byte
    '{'{8'hFE, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h02, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{KIND_MSS, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h03, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{KIND_END, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h80, 1'b1, 1'b1}, 1'b0, NO_RESULT},
    // area ends while a length byte is expected
    '{'{8'h08, 1'b1, 1'b1}, 1'b1, AREA_REJECTED}
  };

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  opt_item_t   item         = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  opt_result_t result;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data     = '0;

  // typed expectation that travels with the item of a directed row
  logic        row_typed    = 1'b0;
  opt_result_t row_result   = '0;

  int idle_odds      = 0;
  int mismatch_count = 0;
  int items_sent     = 0;

  opt_result_t pending_results [$];
  logic [7:0]  area_bytes [$];

  // parser model state
  parse_phase_e area_phase;
  logic [7:0]   opt_kind;
  logic [7:0]   bytes_left;
  logic [7:0]   opt_len;
  logic [15:0]  data_acc;
  logic [15:0]  mss_value;
  logic         mss_found;
  logic [7:0]   scale_value;
  logic         sack_flag;
  logic         area_bad;
  logic [15:0]  mss_default;

  tcp_option_parser_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic clear_area_state();
    area_phase  = PH_KIND;
    opt_kind    = '0;
    bytes_left  = '0;
    opt_len     = '0;
    data_acc    = '0;
    mss_value   = MSS_RESET;
    mss_found   = 1'b0;
    scale_value = '0;
    sack_flag   = 1'b0;
    area_bad    = 1'b0;
  endtask

  task automatic close_option();
    if (opt_kind == KIND_MSS && opt_len == LEN_MSS) begin
      mss_value = data_acc;
      mss_found = 1'b1;
    end else if (opt_kind == KIND_WSCALE && opt_len == LEN_WSCALE) begin
      scale_value = data_acc[7:0];
    end else if (opt_kind == KIND_SACK_OK && opt_len == LEN_SACK) begin
      sack_flag = 1'b1;
    end
    area_phase = PH_KIND;
  endtask

  task automatic take_option_byte(input logic [7:0] b);
    case (area_phase)
      PH_KIND: begin
        if (b == KIND_END) begin
          area_phase = PH_SKIP;
        end else if (b != KIND_NOP) begin
          opt_kind   = b;
          area_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b < LEN_MIN) begin
          area_bad   = 1'b1;
          area_phase = PH_SKIP;
        end else begin
          opt_len    = b;
          bytes_left = b - LEN_MIN;
          data_acc   = '0;
          if (bytes_left == 0) close_option();
          else area_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        // keeps only the last two data bytes
        data_acc   = {data_acc[7:0], b};
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 0) close_option();
      end
      default: ;
    endcase
  endtask

  task automatic parse_item(input opt_item_t it, output bit closes, output opt_result_t res);
    closes = !it.has_byte || it.last_byte;
    res    = '0;
    if (it.has_byte) take_option_byte(it.option_byte);
    if (closes) begin
      if (area_phase == PH_LEN || area_phase == PH_DATA) area_bad = 1'b1;
      if (area_bad) begin
        res = '{1'b0, mss_default, 8'd0, 1'b0};
      end else begin
        res = '{1'b1, mss_found ? mss_value : mss_default, scale_value, sack_flag};
      end
      clear_area_state();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : result_check
    bit          closes;
    opt_result_t predicted;
    opt_result_t want;
    if (rst) begin
      mss_default = MSS_RESET;
      clear_area_state();
    end else begin
      if (cfg_valid && cfg_ready) mss_default = cfg_data;
      if (item_valid && !item_stall) begin
        parse_item(item, closes, predicted);
        if (closes) pending_results.push_back(row_typed ? row_result : predicted);
      end
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(result), 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (result.parse_ok !== want.parse_ok)
            report_mismatch("parse_ok", 32'(result.parse_ok), 32'(want.parse_ok));
          if (result.max_segment_size !== want.max_segment_size)
            report_mismatch("max_segment_size", 32'(result.max_segment_size),
                            32'(want.max_segment_size));
          if (result.window_scale !== want.window_scale)
            report_mismatch("window_scale", 32'(result.window_scale),
                            32'(want.window_scale));
          if (result.sack_permitted !== want.sack_permitted)
            report_mismatch("sack_permitted", 32'(result.sack_permitted),
                            32'(want.sack_permitted));
        end
      end
    end
  end

  // receiver stall bursts
  initial begin : stall_gen
    forever begin
      @(posedge clk);
      if (idle_odds != 0 && $urandom_range(1, 2 * idle_odds) == 1) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input opt_item_t it, input logic typed, input opt_result_t res);
    if (idle_odds != 0 && $urandom_range(1, 2 * idle_odds) == 1) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    row_typed  <= typed;
    row_result <= res;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  task automatic write_mss_default(input logic [15:0] value);
    item_valid <= 1'b0;
    // let the checker queue the last closing transfer first
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_option(input logic [7:0] kind, input logic [7:0] len);
    area_bytes.push_back(kind);
    area_bytes.push_back(len);
    repeat (int'(len) - 2) area_bytes.push_back(8'($urandom));
  endtask

  task automatic build_area(output bit empty_close);
    int          pick;
    int          n_opts;
    logic [7:0]  len;
    area_bytes.delete();
    empty_close = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      empty_close = 1'b1;
    end else if (pick < 70) begin
      n_opts = $urandom_range(1, 5);
      for (int i = 0; i < n_opts; i++) begin
        case ($urandom_range(0, 6))
          0: area_bytes.push_back(KIND_NOP);
          1: push_option(KIND_MSS, LEN_MSS);
          2: push_option(KIND_WSCALE, LEN_WSCALE);
          3: push_option(KIND_SACK_OK, LEN_SACK);
          4: push_option(8'($urandom_range(5, 255)), 8'($urandom_range(2, 7)));
          // known kind, length may be off
          5: push_option(8'($urandom_range(2, 4)), 8'($urandom_range(2, 6)));
          default: begin
            area_bytes.push_back(KIND_END);
            repeat ($urandom_range(0, 4)) area_bytes.push_back(8'($urandom));
            break;
          end
        endcase
      end
    end else if (pick < 85) begin
      if ($urandom_range(0, 1)) push_option(KIND_WSCALE, LEN_WSCALE);
      if ($urandom_range(0, 1)) begin
        // bad length byte, the rest is swallowed
        area_bytes.push_back(8'($urandom_range(2, 255)));
        area_bytes.push_back(8'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 3)) area_bytes.push_back(8'($urandom));
      end else begin
        // option cut short by the end of the area
        len = 8'($urandom_range(3, 255));
        area_bytes.push_back(8'($urandom_range(2, 255)));
        if ($urandom_range(0, 3) != 0) begin
          area_bytes.push_back(len);
          repeat ($urandom_range(0, (len - 3 > 4) ? 4 : len - 3))
            area_bytes.push_back(8'($urandom));
        end
        empty_close = $urandom_range(0, 1);
      end
    end else begin
      repeat ($urandom_range(1, 8)) area_bytes.push_back(8'($urandom));
      empty_close = $urandom_range(0, 1);
    end
  endtask

  initial begin : stimulus
    bit          empty_close;
    int          phase_start;
    logic [15:0] mss_setting;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    idle_odds = 4;

    foreach (DIRECTED[i]) send_item(DIRECTED[i].it, DIRECTED[i].typed, DIRECTED[i].res);

    for (int p = 0; p < PHASES; p++) begin
      mss_setting = (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF :
                    (p == PHASES - 1) ? MSS_RESET : 16'($urandom);
      write_mss_default(mss_setting);
      idle_odds = (p == 2 || p == PHASES - 1) ? 0 : ((p % 2) ? 10 : 3);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        build_area(empty_close);
        foreach (area_bytes[i])
          send_item('{area_bytes[i], 1'b1, !empty_close && i == area_bytes.size() - 1},
                    1'b0, NO_RESULT);
        if (empty_close)
          send_item('{8'($urandom), 1'b0, 1'($urandom)}, 1'b0, NO_RESULT);
      end
    end

    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tcpop_pkg.sv
rtl/tcpop_core.sv
rtl/tcpop_out_reg.sv
rtl/tcp_option_parser_top.sv
test/tcp_option_parser_top_tb.sv
